/* src/s256tc_pkg.sv */
// ----------------------------------------------------------------------------
// s256tc_pkg
// shared types, constants and round functions of the sha-256 tail checker
// ----------------------------------------------------------------------------
package s256tc_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned WIN_WORDS  = 16;
  // input register + one register per round + result register
  localparam int unsigned LATENCY    = NUM_ROUNDS + 2;

  typedef logic [31:0] word_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIDSTATE_AB = 3'd0,
    CFG_MIDSTATE_CD = 3'd1,
    CFG_MIDSTATE_EF = 3'd2,
    CFG_MIDSTATE_GH = 3'd3,
    CFG_TARGET      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // fixed padding of the tail block: 4 data words, pad bit, zeros, bit length
  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam word_t LEN_WORD = 32'h0000_0280;

  typedef struct packed {
    word_t tail_word0;
    word_t tail_word1;
    word_t tail_word2;
    word_t tail_word3;
  } in_word_t;

  typedef struct packed {
    word_t hash_word0;
    logic  is_match;
  } out_word_t;

  // working variables v[0]=a .. v[7]=h, schedule window w[0] = w[t]
  typedef struct packed {
    word_t [7:0]           v;
    word_t [WIN_WORDS-1:0] w;
  } stage_t;

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* src/sha256_midstate_tail_target_check.sv */
// ----------------------------------------------------------------------------
// sha256_midstate_tail_target_check
// padded tail-block sha-256 compression from a midstate, word 0 vs target
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ---------------------------------
// input     in         start_i & !busy_o      data_i   (four tail words)
// result    out        done_o, one cycle      result_o (hash word 0, match flag)
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i (64 bits)
//
// - one word accepted every cycle; busy_o stays low
// - each result passes through the input register, 64 round
//   registers (one sha-256 round and one schedule step each) and the result register
// - the round chain is a plain shift pipeline; the receiver cannot stall, so
//   it never holds and never drops a word
// - reset clears the valid bits and the configuration registers (all zero);
//   payload registers are not reset
//
module sha256_midstate_tail_target_check import s256tc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  in_word_t              data_i,
  output logic                  busy_o,
  output logic                  done_o,
  output out_word_t             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [CFG_DATA_W-1:0] mid_ab_q, mid_cd_q, mid_ef_q, mid_gh_q;
  word_t                 target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_ab_q <= '0;
      mid_cd_q <= '0;
      mid_ef_q <= '0;
      mid_gh_q <= '0;
      target_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIDSTATE_AB: mid_ab_q <= cfg_data_i;
        CFG_MIDSTATE_CD: mid_cd_q <= cfg_data_i;
        CFG_MIDSTATE_EF: mid_ef_q <= cfg_data_i;
        CFG_MIDSTATE_GH: mid_gh_q <= cfg_data_i;
        CFG_TARGET:      target_q <= cfg_data_i[31:0];
        default: ;  // indexes past the register list are ignored
      endcase
    end
  end

  // the pipeline never stalls, so a word is taken whenever start is high
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // input register: working variables from the midstate, padded block
  logic   in_valid_q;
  stage_t in_st_d, in_st_q;

  always_comb begin
    in_st_d.v[0] = mid_ab_q[63:32];
    in_st_d.v[1] = mid_ab_q[31:0];
    in_st_d.v[2] = mid_cd_q[63:32];
    in_st_d.v[3] = mid_cd_q[31:0];
    in_st_d.v[4] = mid_ef_q[63:32];
    in_st_d.v[5] = mid_ef_q[31:0];
    in_st_d.v[6] = mid_gh_q[63:32];
    in_st_d.v[7] = mid_gh_q[31:0];
    in_st_d.w    = '0;
    in_st_d.w[0] = data_i.tail_word0;
    in_st_d.w[1] = data_i.tail_word1;
    in_st_d.w[2] = data_i.tail_word2;
    in_st_d.w[3] = data_i.tail_word3;
    in_st_d.w[4] = PAD_WORD;
    in_st_d.w[WIN_WORDS-1] = LEN_WORD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_st_q <= in_st_d;
    end
  end

  // 64 round stages
  logic   stage_vld [NUM_ROUNDS+1];
  stage_t stage_st  [NUM_ROUNDS+1];

  assign stage_vld[0] = in_valid_q;
  assign stage_st[0]  = in_st_q;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    s256tc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_vld[r]),
      .st_i    (stage_st[r]),
      .k_i     (ROUND_K[r]),
      .valid_o (stage_vld[r+1]),
      .st_o    (stage_st[r+1])
    );
  end

  // result register: feed-forward of word 0 and the target compare, from the live
  // registers; the user keeps config quiet while words are in flight (unenforced)
  logic      res_valid_q;
  out_word_t res_d, res_q;

  always_comb begin
    res_d.hash_word0 = stage_st[NUM_ROUNDS].v[0] + mid_ab_q[63:32];
    res_d.is_match   = (res_d.hash_word0 <= target_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= stage_vld[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_vld[NUM_ROUNDS]) begin
      res_q <= res_d;
    end
  end

  assign done_o   = res_valid_q;
  assign result_o = res_q;

endmodule

/* src/s256tc_round.sv */
// ----------------------------------------------------------------------------
// s256tc_round
// one registered sha-256 round plus one message schedule step
// ----------------------------------------------------------------------------
module s256tc_round import s256tc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  stage_t st_i,
  input  word_t  k_i,
  output logic   valid_o,
  output stage_t st_o
);

  logic   valid_q;
  stage_t st_d, st_q;
  word_t  choose, major, t1, t2, w_new;

  always_comb begin
    choose = (st_i.v[4] & st_i.v[5]) ^ (~st_i.v[4] & st_i.v[6]);
    major  = (st_i.v[0] & st_i.v[1]) ^ (st_i.v[0] & st_i.v[2]) ^ (st_i.v[1] & st_i.v[2]);
    t1     = st_i.v[7] + big_sigma1(st_i.v[4]) + choose + k_i + st_i.w[0];
    t2     = big_sigma0(st_i.v[0]) + major;
    // w[t+16] from w[t], w[t+1], w[t+9], w[t+14]
    w_new  = st_i.w[0] + small_sigma0(st_i.w[1]) + st_i.w[9] + small_sigma1(st_i.w[14]);

    st_d.v[0] = t1 + t2;
    st_d.v[1] = st_i.v[0];
    st_d.v[2] = st_i.v[1];
    st_d.v[3] = st_i.v[2];
    st_d.v[4] = st_i.v[3] + t1;
    st_d.v[5] = st_i.v[4];
    st_d.v[6] = st_i.v[5];
    st_d.v[7] = st_i.v[6];
    for (int i = 0; i < WIN_WORDS - 1; i++) begin
      st_d.w[i] = st_i.w[i+1];
    end
    st_d.w[WIN_WORDS-1] = w_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

/* src/s256tc_checker.sv */
// ----------------------------------------------------------------------------
// s256tc_checker
// port-level timing checks of the tail checker, bound to the top level
// ----------------------------------------------------------------------------
module s256tc_checker import s256tc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      done_o,
  input out_word_t result_o
);

  // the round chain never holds words off
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised by a non-stalling pipeline");

  // every accepted word comes out after the fixed latency
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(LATENCY) done_o)
    else $error("accepted word lost in the round chain");

  // no result without a word accepted the latency before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without a matching word");

  // a zero hash word is at most any target, so it always matches
  a_match_zero_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hash_word0 == 32'h0) |-> result_o.is_match)
    else $error("zero hash word not flagged as match");

endmodule

bind sha256_midstate_tail_target_check s256tc_checker u_s256tc_checker (.*);
